@@ rtl/rgbgm_pkg.sv @@
// Shared types and constants of the RGB gamut mapper.
`default_nettype none

package rgbgm_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic signed [15:0] ONE_Q12   = 16'sd4096;
    localparam logic signed [33:0] THIRD_Q12 = 34'sd1365;
    localparam logic signed [15:0] SAT_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] SAT_MIN   = -16'sh8000;

    localparam logic CMD_CONSTRAIN = 1'b0;
    localparam logic CMD_LIMIT     = 1'b1;

    typedef enum logic [2:0] {
        REG_WHITE   = 3'd0,
        REG_COEF_R  = 3'd1,
        REG_COEF_G  = 3'd2,
        REG_COEF_B  = 3'd3,
        REG_METHOD  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        LIM_LUMA      = 2'd0,
        LIM_THIRD     = 2'd1,
        LIM_CLAMP     = 2'd2,
        LIM_THIRD_ALT = 2'd3
    } t_limit;

    localparam logic [14:0]        RST_WHITE  = 15'd4096;
    localparam logic signed [15:0] RST_COEF_R = 16'sd871;
    localparam logic signed [15:0] RST_COEF_G = 16'sd2929;
    localparam logic signed [15:0] RST_COEF_B = 16'sd296;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic signed [15:0] pixel_luminance;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] red_out;
        logic signed [15:0] green_out;
        logic signed [15:0] blue_out;
        logic               changed;
    } t_out_beat;

    typedef struct packed {
        logic [14:0]        white_luminance;
        logic signed [15:0] y_coef_red;
        logic signed [15:0] y_coef_green;
        logic signed [15:0] y_coef_blue;
        t_limit             limit_method;
    } t_cfg;

    // Pixel context carried alongside the grey-level divider.
    typedef struct packed {
        logic               cmd;
        logic               use_third;
        logic               byp;
        logic               changed;
        logic signed [15:0] byp_r;
        logic signed [15:0] byp_g;
        logic signed [15:0] byp_b;
        logic signed [15:0] ch_r;
        logic signed [15:0] ch_g;
        logic signed [15:0] ch_b;
        logic signed [15:0] mn;
        logic signed [15:0] mx;
    } t_sb1;

    // Result context carried alongside the channel dividers.
    typedef struct packed {
        logic               byp;
        logic               changed;
        logic signed [15:0] byp_r;
        logic signed [15:0] byp_g;
        logic signed [15:0] byp_b;
    } t_sb2;

    typedef struct packed {
        logic under;
        logic over;
    } t_lane;

endpackage

`default_nettype wire

@@ rtl/rgb_gamut_map.sv @@
// Top level of the RGB gamut mapper: front end, dividers and result stage.
// An accepted input beat passes 3 front stages, the 33-stage grey-level
// divider, 3 middle stages, the 16-stage channel dividers and the output
// register on its way to its output beat. Throughput: one beat per
// cycle; the whole pipe holds while the output beat waits for i_out_ready.
// Reset clears all valid bits and restores the registers to their defaults.
`default_nettype none

module rgb_gamut_map (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire rgbgm_pkg::t_in_beat           i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output rgbgm_pkg::t_out_beat               o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rgbgm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rgbgm_pkg::DATA_W-1:0]  pwdata,
    output logic      [rgbgm_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);
    import rgbgm_pkg::*;

    localparam int SB1_W  = $bits(t_sb1);
    localparam int SB2_W  = $bits(t_sb2);
    localparam int LANE_W = $bits(t_lane);

    t_cfg w_cfg;

    rgbgm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // One enable for the whole pipe: advance whenever the output slot frees.
    logic      r_out_valid;
    t_out_beat r_out;
    logic      w_en;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    function automatic logic signed [15:0] clamp01(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v < 0) r = '0;
        else if (v > ONE_Q12) r = ONE_Q12;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stage 1: capture the beat, find smallest and largest channel.
    // ---------------------------------------------------------------
    logic               r1_vld;
    t_in_beat           r1_in;
    logic signed [15:0] r1_mn, r1_mx;
    logic signed [15:0] w_mn, w_mx;

    always_comb begin
        w_mn = i_in.red;
        w_mx = i_in.red;
        if (i_in.green < w_mn) w_mn = i_in.green;
        if (i_in.green > w_mx) w_mx = i_in.green;
        if (i_in.blue < w_mn) w_mn = i_in.blue;
        if (i_in.blue > w_mx) w_mx = i_in.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_in <= i_in;
            r1_mn <= w_mn;
            r1_mx <= w_mx;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: the three terms of the luminance dot product.
    // ---------------------------------------------------------------
    logic               r2_vld;
    t_in_beat           r2_in;
    logic signed [15:0] r2_mn, r2_mx;
    logic signed [31:0] r2_pr, r2_pg, r2_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_in <= r1_in;
            r2_mn <= r1_mn;
            r2_mx <= r1_mx;
            r2_pr <= r1_in.red   * w_cfg.y_coef_red;
            r2_pg <= r1_in.green * w_cfg.y_coef_green;
            r2_pb <= r1_in.blue  * w_cfg.y_coef_blue;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum, white test, classify the pixel, build the dividend.
    // The dividend is offset by white * 2**32 so the floor quotient of a
    // negative sum comes out of an unsigned divider.
    // ---------------------------------------------------------------
    logic               r3_vld;
    logic [47:0]        r3_n1;
    logic [14:0]        r3_w;
    t_sb1               r3_sb;

    logic signed [33:0] w_s;
    logic [14:0]        w_weff;
    logic signed [34:0] w_wq;
    logic               w_to_white;
    logic signed [33:0] w_sel;
    logic signed [48:0] w_n1;
    t_sb1               w_sb1;

    assign w_s        = 34'(r2_pr) + 34'(r2_pg) + 34'(r2_pb);
    assign w_weff     = (w_cfg.white_luminance == '0) ? 15'd1 : w_cfg.white_luminance;
    assign w_wq       = $signed({8'b0, w_weff, 12'b0});
    assign w_to_white = 35'(w_s) > w_wq;
    assign w_sel      = (r2_in.cmd == CMD_LIMIT) ? w_s
                      : $signed({{6{r2_in.pixel_luminance[15]}}, r2_in.pixel_luminance, 12'b0});
    assign w_n1       = 49'(w_sel) + $signed({2'b0, w_weff, 32'b0});

    always_comb begin
        w_sb1           = '0;
        w_sb1.cmd       = r2_in.cmd;
        w_sb1.ch_r      = r2_in.red;
        w_sb1.ch_g      = r2_in.green;
        w_sb1.ch_b      = r2_in.blue;
        w_sb1.mn        = r2_mn;
        w_sb1.mx        = r2_mx;
        w_sb1.byp       = 1'b1;
        w_sb1.byp_r     = r2_in.red;
        w_sb1.byp_g     = r2_in.green;
        w_sb1.byp_b     = r2_in.blue;
        if (r2_in.cmd == CMD_CONSTRAIN) begin
            if (r2_mn < 0) begin
                w_sb1.changed = 1'b1;
                if (r2_in.pixel_luminance < 0) begin
                    // negative luminance: black
                    w_sb1.byp_r = '0;
                    w_sb1.byp_g = '0;
                    w_sb1.byp_b = '0;
                end else begin
                    w_sb1.byp = 1'b0;
                end
            end
        end else if (r2_mx > ONE_Q12) begin
            w_sb1.changed = 1'b1;
            if (w_cfg.limit_method == LIM_CLAMP) begin
                w_sb1.byp_r = clamp01(r2_in.red);
                w_sb1.byp_g = clamp01(r2_in.green);
                w_sb1.byp_b = clamp01(r2_in.blue);
            end else if (w_cfg.limit_method == LIM_LUMA && w_to_white) begin
                w_sb1.byp_r = ONE_Q12;
                w_sb1.byp_g = ONE_Q12;
                w_sb1.byp_b = ONE_Q12;
            end else begin
                w_sb1.byp       = 1'b0;
                w_sb1.use_third = (w_cfg.limit_method != LIM_LUMA);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_n1 <= w_n1[47:0];
            r3_w  <= w_weff;
            r3_sb <= w_sb1;
        end
    end

    // ---------------------------------------------------------------
    // Grey-level divider: l + 2**32 = floor(dividend / white).
    // ---------------------------------------------------------------
    logic             d1_vld;
    logic [32:0]      d1_q;
    logic [SB1_W-1:0] d1_side;
    t_sb1             d1_sb;

    rgbgm_div #(
        .NW (48),
        .DW (15),
        .QW (33),
        .SW (SB1_W)
    ) u_div_grey (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_num   (r3_n1),
        .i_den   (r3_w),
        .i_side  (r3_sb),
        .o_valid (d1_vld),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    assign d1_sb = t_sb1'(d1_side);

    // ---------------------------------------------------------------
    // Stage 4: per-channel product and the common divisor.
    // constrain: num = l*(c-mn), den = l-mn
    // limit:     num = l*(mx-c) + 4096*(c-l), den = mx-l
    // ---------------------------------------------------------------
    logic               r4_vld;
    logic signed [51:0] r4_p [3];
    logic signed [33:0] r4_l;
    logic [33:0]        r4_d;
    t_sb1               r4_sb;

    logic signed [33:0] w_l;
    logic signed [15:0] w_c4 [3];
    logic signed [17:0] w_a  [3];
    logic signed [34:0] w_d;

    assign w_l = d1_sb.use_third ? THIRD_Q12
               : $signed({1'b0, d1_q} - {2'b01, 32'b0});
    assign w_c4[0] = d1_sb.ch_r;
    assign w_c4[1] = d1_sb.ch_g;
    assign w_c4[2] = d1_sb.ch_b;
    assign w_d = (d1_sb.cmd == CMD_LIMIT) ? 35'(d1_sb.mx) - 35'(w_l)
                                          : 35'(w_l) - 35'(d1_sb.mn);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k] = (d1_sb.cmd == CMD_LIMIT) ? 18'(d1_sb.mx) - 18'(w_c4[k])
                                              : 18'(w_c4[k]) - 18'(d1_sb.mn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r4_p[k] <= w_l * w_a[k];
            end
            r4_l  <= w_l;
            r4_d  <= w_d[33:0];
            r4_sb <= d1_sb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: finish the numerator and add den * 2**15 so the signed
    // floor quotient maps onto an unsigned 16-bit quotient.
    // ---------------------------------------------------------------
    logic               r5_vld;
    logic signed [52:0] r5_np [3];
    logic [33:0]        r5_d;
    t_sb1               r5_sb;

    logic signed [15:0] w_c5 [3];
    logic signed [52:0] w_np [3];

    assign w_c5[0] = r4_sb.ch_r;
    assign w_c5[1] = r4_sb.ch_g;
    assign w_c5[2] = r4_sb.ch_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [34:0] cl;
            logic signed [46:0] t;
            logic signed [52:0] n;
            cl = 35'(w_c5[k]) - 35'(r4_l);
            t  = $signed({cl, 12'b0});
            n  = (r4_sb.cmd == CMD_LIMIT) ? 53'(r4_p[k]) + 53'(t) : 53'(r4_p[k]);
            w_np[k] = n + $signed({4'b0, r4_d, 15'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_np <= w_np;
            r5_d  <= r4_d;
            r5_sb <= r4_sb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: saturation detect; quotient below -32768 or above 32767.
    // ---------------------------------------------------------------
    logic        r6_vld;
    logic [49:0] r6_num [3];
    t_lane       r6_lane [3];
    logic [33:0] r6_d;
    t_sb2        r6_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r6_num[k]        <= r5_np[k][49:0];
                r6_lane[k].under <= r5_np[k][52];
                r6_lane[k].over  <= r5_np[k] >= $signed({3'b0, r5_d, 16'b0});
            end
            r6_d          <= r5_d;
            r6_sb.byp     <= r5_sb.byp;
            r6_sb.changed <= r5_sb.changed;
            r6_sb.byp_r   <= r5_sb.byp_r;
            r6_sb.byp_g   <= r5_sb.byp_g;
            r6_sb.byp_b   <= r5_sb.byp_b;
        end
    end

    // ---------------------------------------------------------------
    // Channel dividers; lane 0 also carries the result context.
    // ---------------------------------------------------------------
    logic                      d2_vld [3];
    logic [15:0]               d2_q   [3];
    logic [SB2_W+LANE_W-1:0]   d2_side0;
    logic [LANE_W-1:0]         d2_side1, d2_side2;
    t_sb2                      d2_sb;
    t_lane                     d2_lane [3];

    rgbgm_div #(
        .NW (50),
        .DW (34),
        .QW (16),
        .SW (SB2_W + LANE_W)
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_num   (r6_num[0]),
        .i_den   (r6_d),
        .i_side  ({r6_sb, r6_lane[0]}),
        .o_valid (d2_vld[0]),
        .o_quo   (d2_q[0]),
        .o_side  (d2_side0)
    );

    rgbgm_div #(
        .NW (50),
        .DW (34),
        .QW (16),
        .SW (LANE_W)
    ) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_num   (r6_num[1]),
        .i_den   (r6_d),
        .i_side  (r6_lane[1]),
        .o_valid (d2_vld[1]),
        .o_quo   (d2_q[1]),
        .o_side  (d2_side1)
    );

    rgbgm_div #(
        .NW (50),
        .DW (34),
        .QW (16),
        .SW (LANE_W)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_vld),
        .i_num   (r6_num[2]),
        .i_den   (r6_d),
        .i_side  (r6_lane[2]),
        .o_valid (d2_vld[2]),
        .o_quo   (d2_q[2]),
        .o_side  (d2_side2)
    );

    assign d2_sb      = t_sb2'(d2_side0[SB2_W+LANE_W-1:LANE_W]);
    assign d2_lane[0] = t_lane'(d2_side0[LANE_W-1:0]);
    assign d2_lane[1] = t_lane'(d2_side1);
    assign d2_lane[2] = t_lane'(d2_side2);

    // ---------------------------------------------------------------
    // Output register: saturate, undo the quotient offset, pick bypass.
    // ---------------------------------------------------------------
    logic signed [15:0] w_val [3];
    logic               w_out_vld;

    assign w_out_vld = d2_vld[0] && d2_vld[1] && d2_vld[2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (d2_lane[k].under)     w_val[k] = SAT_MIN;
            else if (d2_lane[k].over) w_val[k] = SAT_MAX;
            else                      w_val[k] = $signed({~d2_q[k][15], d2_q[k][14:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.red_out   <= d2_sb.byp ? d2_sb.byp_r : w_val[0];
            r_out.green_out <= d2_sb.byp ? d2_sb.byp_g : w_val[1];
            r_out.blue_out  <= d2_sb.byp ? d2_sb.byp_b : w_val[2];
            r_out.changed   <= d2_sb.changed;
        end
    end

`ifndef SYNTHESIS
    // A waiting output beat must hold the whole pipe.
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output beat stalled");

    // An accepted beat enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r1_vld)
        else $error("accepted beat lost at stage 1");

    // A divided result only ever belongs to a pixel that was out of gamut.
    a_divided_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2_vld[0] && !d2_sb.byp) |-> d2_sb.changed)
        else $error("divider result on an unchanged pixel");
`endif

endmodule

`default_nettype wire

@@ rtl/rgbgm_cfg.sv @@
// APB register file of the RGB gamut mapper.
`default_nettype none

module rgbgm_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rgbgm_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [rgbgm_pkg::DATA_W-1:0]      pwdata,
    output logic      [rgbgm_pkg::DATA_W-1:0]      prdata,
    output logic                                   pready,
    output rgbgm_pkg::t_cfg                        o_cfg
);
    import rgbgm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_luminance <= RST_WHITE;
            r_cfg.y_coef_red      <= RST_COEF_R;
            r_cfg.y_coef_green    <= RST_COEF_G;
            r_cfg.y_coef_blue     <= RST_COEF_B;
            r_cfg.limit_method    <= LIM_LUMA;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_WHITE:  r_cfg.white_luminance <= pwdata[14:0];
                REG_COEF_R: r_cfg.y_coef_red      <= pwdata[15:0];
                REG_COEF_G: r_cfg.y_coef_green    <= pwdata[15:0];
                REG_COEF_B: r_cfg.y_coef_blue     <= pwdata[15:0];
                REG_METHOD: r_cfg.limit_method    <= t_limit'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_WHITE:  prdata = {17'b0, r_cfg.white_luminance};
            REG_COEF_R: prdata = {16'b0, r_cfg.y_coef_red};
            REG_COEF_G: prdata = {16'b0, r_cfg.y_coef_green};
            REG_COEF_B: prdata = {16'b0, r_cfg.y_coef_blue};
            REG_METHOD: prdata = {30'b0, r_cfg.limit_method};
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rgbgm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rgbgm_div #(
    parameter int NW = 48,
    parameter int DW = 15,
    parameter int QW = 33,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic      [QW-1:0] o_quo,
    output logic      [SW-1:0] o_side
);

    // Numerator must stay below den * 2**QW.
    logic          r_vld  [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic          w_vld_in;
        logic [NW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [SW-1:0] w_side_in;
        logic [NW-1:0] w_dsh;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_rem_in  = i_num;
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign w_dsh = NW'(w_den_in) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_dsh) begin
                    r_rem[k] <= w_rem_in - w_dsh;
                    r_quo[k] <= w_quo_in | (QW'(1) << SH);
                end else begin
                    r_rem[k] <= w_rem_in;
                    r_quo[k] <= w_quo_in;
                end
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

@@ verif/tb_rgb_gamut_map.sv @@
// Self-checking testbench of the RGB gamut mapper: random and directed pixel beats.
`default_nettype none

module tb_rgb_gamut_map;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbgm_pkg::*;

    // Expected-pixel store: compute the mapped pixel of every accepted beat and
    // compare each output beat with the oldest one still waiting.
    class gamut_scoreboard;
        longint    white;
        longint    coef_r;
        longint    coef_g;
        longint    coef_b;
        t_limit    method;
        t_out_beat expected_pixels[$];
        int        errors;

        function void restore_defaults();
            white  = longint'(RST_WHITE);
            coef_r = longint'(RST_COEF_R);
            coef_g = longint'(RST_COEF_G);
            coef_b = longint'(RST_COEF_B);
            method = LIM_LUMA;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_WHITE:  white  = longint'(value[14:0]);
                REG_COEF_R: coef_r = longint'(signed'(value[15:0]));
                REG_COEF_G: coef_g = longint'(signed'(value[15:0]));
                REG_COEF_B: coef_b = longint'(signed'(value[15:0]));
                REG_METHOD: method = t_limit'(value[1:0]);
                default: ;
            endcase
        endfunction

        // Division rounding toward minus infinity, divisor positive.
        function longint div_floor(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q--;
            return q;
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767)
                return SAT_MAX;
            if (v < -32768)
                return SAT_MIN;
            return v[15:0];
        endfunction

        function void note_pixel(t_in_beat px);
            longint    ch[3];
            longint    res[3];
            longint    w, mn, mx, lum, grey, s, v;
            logic      chg;
            t_out_beat exp_px;
            ch[0] = longint'(px.red);
            ch[1] = longint'(px.green);
            ch[2] = longint'(px.blue);
            lum   = longint'(px.pixel_luminance);
            w     = (white == 0) ? 1 : white;
            chg   = 1'b0;
            mn    = ch[0];
            mx    = ch[0];
            for (int i = 1; i < 3; i++) begin
                if (ch[i] < mn) mn = ch[i];
                if (ch[i] > mx) mx = ch[i];
            end
            for (int i = 0; i < 3; i++)
                res[i] = ch[i];
            if (px.cmd == CMD_CONSTRAIN) begin
                if (mn < 0) begin
                    chg = 1'b1;
                    if (lum < 0) begin
                        res = '{0, 0, 0};
                    end else begin
                        grey = (lum * 4096) / w;
                        for (int i = 0; i < 3; i++)
                            res[i] = (grey * (ch[i] - mn)) / (grey - mn);
                    end
                end
            end else if (mx > 4096) begin
                chg = 1'b1;
                if (method == LIM_CLAMP) begin
                    for (int i = 0; i < 3; i++) begin
                        v = ch[i];
                        if (v < 0) v = 0;
                        if (v > 4096) v = 4096;
                        res[i] = v;
                    end
                end else if (method == LIM_LUMA &&
                             coef_r * ch[0] + coef_g * ch[1] + coef_b * ch[2] > w * 4096) begin
                    // brighter than white: snap to white
                    res = '{4096, 4096, 4096};
                end else begin
                    if (method == LIM_LUMA) begin
                        s    = coef_r * ch[0] + coef_g * ch[1] + coef_b * ch[2];
                        grey = div_floor(s, w);
                    end else begin
                        grey = 1365;
                    end
                    for (int i = 0; i < 3; i++)
                        res[i] = div_floor(grey * (mx - ch[i]) + 4096 * (ch[i] - grey),
                                           mx - grey);
                end
            end
            exp_px.red_out   = sat16(res[0]);
            exp_px.green_out = sat16(res[1]);
            exp_px.blue_out  = sat16(res[2]);
            exp_px.changed   = chg;
            expected_pixels.push_back(exp_px);
        endfunction

        function void check_pixel(t_out_beat got);
            t_out_beat exp_px;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected output beat %h", $time, got);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.red_out !== exp_px.red_out) begin
                $display("%0t: red_out expected %0d actual %0d", $time,
                         exp_px.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== exp_px.green_out) begin
                $display("%0t: green_out expected %0d actual %0d", $time,
                         exp_px.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== exp_px.blue_out) begin
                $display("%0t: blue_out expected %0d actual %0d", $time,
                         exp_px.blue_out, got.blue_out);
                errors++;
            end
            if (got.changed !== exp_px.changed) begin
                $display("%0t: changed expected %0b actual %0b", $time,
                         exp_px.changed, got.changed);
                errors++;
            end
        endfunction
    endclass

    localparam int PIPE_DEPTH = 56;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 20000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_beat            i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_beat           o_out;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    gamut_scoreboard pixel_sb = new();
    int  in_beats = 0;
    int  idle_cycles = 0;
    logic hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_mode = 0;
    int  stall_window = 0;

    rgb_gamut_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sample both channels at the rising edge; note accepted pixels and check
    // output beats. Count cycles with work pending but no beat moving.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pixel_sb.note_pixel(i_in);
                in_beats++;
            end
            if (o_out_valid && i_out_ready)
                pixel_sb.check_pixel(o_out);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else if (i_in_valid || pixel_sb.expected_pixels.size() != 0)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: stall on its own pattern, re-picked every window; a hold
    // request blocks the output for a long counted stretch.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (stall_window == 0) begin
            stall_window = $urandom_range(20, 120);
            stall_mode   = $urandom_range(0, 3);
        end
        stall_window--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Write one register through a setup and an access cycle.
    task automatic cfg_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pixel_sb.write_reg(idx, value);
    endtask

    // Offer one pixel beat and hold it until the block takes it.
    task automatic send_pixel(t_in_beat px);
        int seen;
        seen = in_beats;
        i_in_valid <= 1'b1;
        i_in       <= px;
        @(negedge i_clk);
        while (in_beats == seen)
            @(negedge i_clk);
    endtask

    // Drop valid and idle for a number of cycles.
    task automatic idle_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Pause until every expected pixel is back and the pipe has drained.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pixel_sb.expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 8) @(negedge i_clk);
    endtask

    function automatic t_in_beat make_pixel(logic cmd, int r, int g, int b, int lum);
        t_in_beat px;
        px.cmd             = cmd;
        px.red             = r[15:0];
        px.green           = g[15:0];
        px.blue            = b[15:0];
        px.pixel_luminance = lum[15:0];
        return px;
    endfunction

    function automatic logic signed [15:0] rand_channel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 4096));
            2: return 16'($signed($urandom_range(0, 14000)) - 5000);
            default: return 16'($signed($urandom_range(0, 1200)) - 300 + 4096);
        endcase
    endfunction

    function automatic t_in_beat rand_pixel();
        t_in_beat px;
        px.cmd             = 1'($urandom_range(0, 1));
        px.red             = rand_channel();
        px.green           = rand_channel();
        px.blue            = rand_channel();
        px.pixel_luminance = ($urandom_range(0, 1) == 0) ? 16'($urandom())
                                                         : 16'($urandom_range(0, 8192));
        return px;
    endfunction

    // Random traffic in bursts; the receiver may be asked for a long hold
    // while the sender keeps offering back to back.
    task automatic random_pixels(int count, logic long_hold);
        int left, burst;
        left = count;
        if (long_hold)
            hold_req = 1'b1;
        while (left > 0) begin
            burst = long_hold ? left : $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_pixel(rand_pixel());
            left -= burst;
            if (!long_hold && $urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 8));
        end
    endtask

    initial begin
        pixel_sb.restore_defaults();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners at reset settings
        send_pixel(make_pixel(CMD_CONSTRAIN, 1000, 2000, 3000, 500));
        send_pixel(make_pixel(CMD_CONSTRAIN, -32768, -32768, -32768, 32767));
        send_pixel(make_pixel(CMD_CONSTRAIN, -100, 2000, 3000, -1));
        send_pixel(make_pixel(CMD_CONSTRAIN, -100, 2000, 3000, -32768));
        send_pixel(make_pixel(CMD_CONSTRAIN, -100, 2000, 3000, 0));
        send_pixel(make_pixel(CMD_CONSTRAIN, -32768, 32767, 0, 32767));
        send_pixel(make_pixel(CMD_CONSTRAIN, 0, 0, 0, 0));
        send_pixel(make_pixel(CMD_LIMIT, 4096, 4096, 4096, 0));
        send_pixel(make_pixel(CMD_LIMIT, 4097, 0, 0, 0));
        send_pixel(make_pixel(CMD_LIMIT, 32767, 32767, 32767, 0));
        send_pixel(make_pixel(CMD_LIMIT, 8000, 8000, 8000, 0));
        send_pixel(make_pixel(CMD_LIMIT, 32767, -32768, -32768, -32768));
        send_pixel(make_pixel(CMD_LIMIT, 6000, 100, -2000, 0));
        send_pixel(make_pixel(CMD_LIMIT, -32768, -32768, -32768, 0));
        random_pixels(180, 1'b0);
        drain();

        // fixed third, tiny white
        cfg_write(REG_METHOD, LIM_THIRD);
        cfg_write(REG_WHITE, 32'd1);
        send_pixel(make_pixel(CMD_LIMIT, 32767, 0, 5000, 0));
        send_pixel(make_pixel(CMD_CONSTRAIN, -5, 10, 20, 32767));
        random_pixels(180, 1'b1);
        drain();

        // plain clamp, largest white, coefficient extremes
        cfg_write(REG_METHOD, LIM_CLAMP);
        cfg_write(REG_WHITE, 32'd32767);
        cfg_write(REG_COEF_R, 32'h0000_8000);
        cfg_write(REG_COEF_G, 32'h0000_7FFF);
        cfg_write(REG_COEF_B, 32'h0000_8000);
        send_pixel(make_pixel(CMD_LIMIT, 32767, -32768, 4100, 0));
        random_pixels(180, 1'b0);
        drain();

        // luminance mode with extreme coefficients, white written as zero
        cfg_write(REG_METHOD, LIM_LUMA);
        cfg_write(REG_WHITE, 32'd0);
        random_pixels(180, 1'b0);
        drain();

        cfg_write(REG_WHITE, 32'd32767);
        cfg_write(REG_COEF_R, 32'h0000_7FFF);
        cfg_write(REG_COEF_G, 32'h0000_8000);
        cfg_write(REG_COEF_B, 32'h0000_7FFF);
        random_pixels(140, 1'b0);
        drain();

        // alternate third code, random coefficients
        cfg_write(REG_METHOD, LIM_THIRD_ALT);
        cfg_write(REG_WHITE, $urandom_range(1, 32767));
        cfg_write(REG_COEF_R, $urandom());
        cfg_write(REG_COEF_G, $urandom());
        cfg_write(REG_COEF_B, $urandom());
        random_pixels(140, 1'b0);
        drain();

        cfg_write(REG_METHOD, LIM_LUMA);
        cfg_write(REG_WHITE, 32'd4096);
        cfg_write(REG_COEF_R, 32'd871);
        cfg_write(REG_COEF_G, 32'd2929);
        cfg_write(REG_COEF_B, 32'd296);
        random_pixels(140, 1'b0);
        drain();

        if (pixel_sb.expected_pixels.size() != 0) begin
            $display("%0t: %0d expected pixels never arrived", $time,
                     pixel_sb.expected_pixels.size());
            pixel_sb.errors++;
        end
        if (pixel_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
